// ===== src/rmq_pkg.sv =====
// Shared constants and types for the rotation matrix to quaternion block.
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   typedef logic [1:0] branch_type;

   localparam branch_type BR_TRACE = 2'd0;
   localparam branch_type BR_X     = 2'd1;
   localparam branch_type BR_Y     = 2'd2;
   localparam branch_type BR_Z     = 2'd3;

endpackage

// ===== src/rmq_prep.sv =====
// Entry stage: trace, branch choice, radicand and the three numerators.
module rmq_prep #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   parameter int HR         = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [9*DATA_WIDTH-1:0]     in_mat,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [2*HR-1:0]             out_x,
   output rmq_pkg::branch_type         out_branch,
   output logic signed [DATA_WIDTH:0]  out_num [3]
);

   localparam int RW = DATA_WIDTH + 3;
   localparam int NW = DATA_WIDTH + 1;

   logic signed [RW-1:0] a [9];
   logic signed [RW-1:0] one_q;
   logic signed [RW-1:0] trace;
   logic signed [RW-1:0] rad;
   logic signed [NW-1:0] n [3];
   logic signed [NW-1:0] e [9];
   rmq_pkg::branch_type  branch;

   logic                 valid_ff;
   logic [2*HR-1:0]      x_ff;
   rmq_pkg::branch_type  branch_ff;
   logic signed [NW-1:0] num_ff [3];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         a[k] = RW'(signed'(in_mat[k*DATA_WIDTH +: DATA_WIDTH]));
         e[k] = NW'(signed'(in_mat[k*DATA_WIDTH +: DATA_WIDTH]));
      end
   end

   assign one_q = RW'(1) <<< FRAC_BITS;
   assign trace = a[0] + a[4] + a[8];

   always_comb begin
      priority if (trace > 0) begin
         branch = rmq_pkg::BR_TRACE;
         rad    = trace + one_q;
         n[0]   = e[7] - e[5];
         n[1]   = e[2] - e[6];
         n[2]   = e[3] - e[1];
      end else if (a[0] > a[4] && a[0] > a[8]) begin
         branch = rmq_pkg::BR_X;
         rad    = one_q + a[0] - a[4] - a[8];
         n[0]   = e[7] - e[5];
         n[1]   = e[1] + e[3];
         n[2]   = e[2] + e[6];
      end else if (a[4] > a[8]) begin
         branch = rmq_pkg::BR_Y;
         rad    = one_q + a[4] - a[0] - a[8];
         n[0]   = e[2] - e[6];
         n[1]   = e[1] + e[3];
         n[2]   = e[5] + e[7];
      end else begin
         branch = rmq_pkg::BR_Z;
         rad    = one_q + a[8] - a[0] - a[4];
         n[0]   = e[3] - e[1];
         n[1]   = e[2] + e[6];
         n[2]   = e[5] + e[7];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         // radicand scaled by 2^FRAC_BITS so the root lands in the input Q format
         x_ff      <= (rad > 0) ? ((2*HR)'(rad[DATA_WIDTH+1:0]) << FRAC_BITS) : '0;
         branch_ff <= branch;
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= n[k];
         end
      end
   end

   assign out_valid  = valid_ff;
   assign out_x      = x_ff;
   assign out_branch = branch_ff;
   assign out_num    = num_ff;

endmodule

// ===== src/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt #(
   parameter int HR     = 16,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [2*HR-1:0]   in_x,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [HR-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [HR];
   logic [HR+1:0]     rem_ff   [HR];
   logic [HR-1:0]     root_ff  [HR];
   logic [2*HR-1:0]   x_ff     [HR];
   logic [SIDE_W-1:0] side_ff  [HR];
   logic              rdy      [HR+1];

   assign rdy[HR] = out_ready;

   for (genvar s = 0; s < HR; s++) begin : g_stage
      logic              v_prev;
      logic [HR+1:0]     rem_prev;
      logic [HR-1:0]     root_prev;
      logic [2*HR-1:0]   x_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [HR+3:0]     rem2;
      logic [HR+3:0]     trial;
      logic              ge;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = in_x;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign x_prev    = x_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign rem2   = {rem_prev, x_prev[2*HR-1 -: 2]};
      assign trial  = {2'b00, root_prev, 2'b01};
      assign ge     = rem2 >= trial;
      assign rdy[s] = !valid_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            rem_ff[s]  <= ge ? (HR+2)'(rem2 - trial) : (HR+2)'(rem2);
            root_ff[s] <= {root_prev[HR-2:0], ge};
            x_ff[s]    <= x_prev << 2;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[HR-1];
   assign out_root  = root_ff[HR-1];
   assign out_side  = side_ff[HR-1];

endmodule

// ===== src/rmq_div.sv =====
// Three-lane pipelined divider: |n| * 2^FRAC_BITS / (2r), one quotient bit per stage.
module rmq_div #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   parameter int HR         = 16,
   parameter int SIDE_W     = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [DATA_WIDTH:0] in_num [3],
   input  logic [HR-1:0]              in_root,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [DATA_WIDTH:0]        out_quo  [3],
   output logic                       out_ovf  [3],
   output logic                       out_neg  [3],
   output logic [HR-1:0]              out_root,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int QB  = DATA_WIDTH + 1;
   localparam int NMW = DATA_WIDTH + 1 + FRAC_BITS;
   localparam int CW  = FRAC_BITS + HR + 1;
   localparam int NS  = QB + 1;

   logic              valid_ff [NS];
   logic [HR-1:0]     root_ff  [NS];
   logic [SIDE_W-1:0] side_ff  [NS];
   logic [HR+1:0]     rem_ff   [NS][3];
   logic [QB-1:0]     low_ff   [NS][3];
   logic [QB-1:0]     q_ff     [NS][3];
   logic              ovf_ff   [NS][3];
   logic              neg_ff   [NS][3];
   logic              rdy      [NS+1];

   assign rdy[NS] = out_ready;

   // setup stage: magnitude, overflow test and the leading remainder
   logic [HR:0] div0;
   assign div0   = {in_root, 1'b0};
   assign rdy[0] = !valid_ff[0] || rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane0
      logic [DATA_WIDTH:0] mag;
      logic [NMW-1:0]      nsh;
      logic                ovf;
      assign mag = in_num[l][DATA_WIDTH] ? (DATA_WIDTH+1)'(-in_num[l])
                                         : (DATA_WIDTH+1)'(in_num[l]);
      assign nsh = NMW'(mag) << FRAC_BITS;
      // quotient would need more than QB bits (or the root is zero)
      assign ovf = CW'(nsh[NMW-1:QB]) >= CW'(div0);

      always_ff @(posedge clock) begin
         if (rdy[0]) begin
            rem_ff[0][l] <= ovf ? '0 : (HR+2)'(nsh[NMW-1:QB]);
            low_ff[0][l] <= nsh[QB-1:0];
            q_ff[0][l]   <= '0;
            ovf_ff[0][l] <= ovf;
            neg_ff[0][l] <= in_num[l][DATA_WIDTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         root_ff[0] <= in_root;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_stage
      logic [HR:0] dv;
      assign dv     = {root_ff[s-1], 1'b0};
      assign rdy[s] = !valid_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            root_ff[s] <= root_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [HR+1:0] rem2;
         logic          ge;
         assign rem2 = {rem_ff[s-1][l][HR:0], low_ff[s-1][l][QB-1]};
         assign ge   = rem2 >= {1'b0, dv};

         always_ff @(posedge clock) begin
            if (rdy[s]) begin
               rem_ff[s][l] <= ge ? (HR+2)'(rem2 - {1'b0, dv}) : rem2;
               low_ff[s][l] <= low_ff[s-1][l] << 1;
               q_ff[s][l]   <= {q_ff[s-1][l][QB-2:0], ge};
               ovf_ff[s][l] <= ovf_ff[s-1][l];
               neg_ff[s][l] <= neg_ff[s-1][l];
            end
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         out_quo[l] = q_ff[NS-1][l];
         out_ovf[l] = ovf_ff[NS-1][l];
         out_neg[l] = neg_ff[NS-1][l];
      end
   end

endmodule

// ===== src/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix to quaternion, Shepperd's trace-branched method.
// Pipeline from the accepting edge to rsp_tvalid: entry stage, one stage per root bit,
//   a setup stage and one stage per quotient bit, then the output register.
// Throughput: one word per cycle while rsp_tready is high; the root and divider pipelines
//   take a new word each cycle when not stalled.
// Reset: synchronous, active high; clears all valid bits, data registers keep their contents.
module rotation_matrix_to_quaternion #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // m00 m01 m02 m10 m11 m12 m20 m21 m22 from bit 0 up, zero padded to bytes
   input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // w_part x_part y_part z_part from bit 0 up, zero padded to bytes
   output logic [((4*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // branch_used [1:0], degenerate [2]
   output logic [2:0]           rsp_tuser
);

   localparam int W     = DATA_WIDTH;
   localparam int XW    = W + 2 + FRAC_BITS;
   localparam int HR    = (XW + 1) / 2;
   localparam int SIDEW = 2 + 3 * (W + 1);
   localparam int OTW   = ((4*W+7)/8)*8;
   localparam int CW    = HR + W;

   // entry stage
   logic                 prep_valid, prep_ready;
   logic [2*HR-1:0]      prep_x;
   rmq_pkg::branch_type  prep_branch;
   logic signed [W:0]    prep_num [3];

   rmq_prep #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .HR(HR)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_mat     (req_tdata[9*W-1:0]),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .out_x      (prep_x),
      .out_branch (prep_branch),
      .out_num    (prep_num)
   );

   // square root, numerators and branch ride along as sideband
   logic              sq_valid, sq_ready;
   logic [HR-1:0]     sq_root;
   logic [SIDEW-1:0]  sq_side_in, sq_side;
   logic signed [W:0] sq_num [3];

   assign sq_side_in = {prep_branch, prep_num[2], prep_num[1], prep_num[0]};

   rmq_sqrt #(.HR(HR), .SIDE_W(SIDEW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_x      (prep_x),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sq_num[l] = signed'(sq_side[l*(W+1) +: W+1]);
      end
   end

   // dividers
   logic                 dv_valid, dv_ready;
   logic [W:0]           dv_quo [3];
   logic                 dv_ovf [3];
   logic                 dv_neg [3];
   logic [HR-1:0]        dv_root;
   rmq_pkg::branch_type  dv_branch;

   rmq_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .HR(HR), .SIDE_W(2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_num    (sq_num),
      .in_root   (sq_root),
      .in_side   (sq_side[SIDEW-1 -: 2]),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf),
      .out_neg   (dv_neg),
      .out_root  (dv_root),
      .out_side  (dv_branch)
   );

   // saturation of the three quotients and the diagonal term
   logic signed [W-1:0] sat_q [3];
   logic signed [W-1:0] diag;
   logic signed [W-1:0] comp [4];
   logic [HR-1:0]       half_root;
   logic                degen;

   localparam logic signed [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (!dv_neg[l]) begin
            sat_q[l] = (dv_ovf[l] || dv_quo[l][W:W-1] != 2'b00) ? SAT_HI : W'(dv_quo[l]);
         end else begin
            // magnitude 2^(W-1) still fits as the most negative value
            sat_q[l] = (dv_ovf[l] || dv_quo[l] > (W+1)'(1) << (W-1)) ? SAT_LO
                                                                       : W'(-dv_quo[l]);
         end
      end
   end

   assign half_root = dv_root >> 1;
   assign diag      = (CW'(half_root) > CW'(SAT_HI)) ? SAT_HI : W'(half_root);
   assign degen     = dv_root == '0;

   // branch term is r/2, the remaining three take the lanes in ascending order
   always_comb begin
      unique case (dv_branch)
         rmq_pkg::BR_TRACE: begin
            comp[0] = diag;     comp[1] = sat_q[0]; comp[2] = sat_q[1]; comp[3] = sat_q[2];
         end
         rmq_pkg::BR_X: begin
            comp[0] = sat_q[0]; comp[1] = diag;     comp[2] = sat_q[1]; comp[3] = sat_q[2];
         end
         rmq_pkg::BR_Y: begin
            comp[0] = sat_q[0]; comp[1] = sat_q[1]; comp[2] = diag;     comp[3] = sat_q[2];
         end
         default: begin
            comp[0] = sat_q[0]; comp[1] = sat_q[1]; comp[2] = sat_q[2]; comp[3] = diag;
         end
      endcase
   end

   // output register
   logic                out_valid_ff;
   logic [4*W-1:0]      out_data_ff;
   rmq_pkg::branch_type out_branch_ff;
   logic                out_degen_ff;

   assign dv_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dv_ready) begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         out_data_ff   <= degen ? '0 : {comp[3], comp[2], comp[1], comp[0]};
         out_branch_ff <= dv_branch;
         out_degen_ff  <= degen;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OTW'(out_data_ff);
   assign rsp_tuser  = {out_degen_ff, out_branch_ff};

   // a degenerate word carries zero components
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_degen_ff |-> out_data_ff == '0)
      else $error("degenerate word with non-zero components");

   // on the trace branch w is r/2 and never negative
   a_trace_w : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_branch_ff == rmq_pkg::BR_TRACE |-> !out_data_ff[W-1])
      else $error("negative w on trace branch");

   // an empty output register lets the whole pipeline move
   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("input stalled with empty output");

endmodule

// ===== dv/tb_rotation_matrix_to_quaternion.sv =====
// Testbench for the rotation matrix to quaternion block: directed table then random words.
module tb_rotation_matrix_to_quaternion;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW      = rmq_pkg::DATA_WIDTH_DEF;
   localparam int FB      = rmq_pkg::FRAC_BITS_DEF;
   localparam int REQ_W   = ((9*DW+7)/8)*8;
   localparam int RSP_W   = ((4*DW+7)/8)*8;
   localparam int LATENCY = 35;
   localparam int N_RAND  = 600;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [DW-1:0] elem_type;
   typedef longint unsigned u64_type;

   typedef struct packed {
      logic                degenerate;
      rmq_pkg::branch_type branch;
      elem_type            z_part;
      elem_type            y_part;
      elem_type            x_part;
      elem_type            w_part;
   } quat_type;

   // one directed row: nine elements, and a typed-in result where obvious
   typedef struct {
      elem_type m[9];
      bit       known;
      quat_type q;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [2:0]       rsp_tuser;

   quat_type quat_queue[$];
   int     mismatches = 0;
   int     words_in = 0;
   int     words_out = 0;
   int     branch_seen[4] = '{0, 0, 0, 0};
   longint cycles = 0;
   bit     stim_done = 1'b0;

   rotation_matrix_to_quaternion dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // integer square root, floor
   function automatic u64_type isqrt(u64_type x);
      u64_type root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic elem_type clamp(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (DW-1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return elem_type'(v);
   endfunction

   // Shepperd conversion: picks the branch, takes the root, divides the rest by 2r
   function automatic quat_type quaternion_of(elem_type m[9]);
      longint a[9];
      longint trace, rad, q;
      longint num[4];
      longint comp[4];
      u64_type root, mag;
      int br;
      quat_type res;
      for (int i = 0; i < 9; i++) a[i] = longint'(m[i]);
      trace = a[0] + a[4] + a[8];
      if (trace > 0) begin
         br = int'(rmq_pkg::BR_TRACE);
         rad = trace + (64'sd1 <<< FB);
         num[1] = a[7] - a[5]; num[2] = a[2] - a[6]; num[3] = a[3] - a[1];
      end else if (a[0] > a[4] && a[0] > a[8]) begin
         br = int'(rmq_pkg::BR_X);
         rad = (64'sd1 <<< FB) + a[0] - a[4] - a[8];
         num[0] = a[7] - a[5]; num[2] = a[1] + a[3]; num[3] = a[2] + a[6];
      end else if (a[4] > a[8]) begin
         br = int'(rmq_pkg::BR_Y);
         rad = (64'sd1 <<< FB) + a[4] - a[0] - a[8];
         num[0] = a[2] - a[6]; num[1] = a[1] + a[3]; num[3] = a[5] + a[7];
      end else begin
         br = int'(rmq_pkg::BR_Z);
         rad = (64'sd1 <<< FB) + a[8] - a[0] - a[4];
         num[0] = a[3] - a[1]; num[1] = a[2] + a[6]; num[2] = a[5] + a[7];
      end
      num[br] = 0;
      root = (rad > 0) ? isqrt(u64_type'(rad) << FB) : 0;
      for (int k = 0; k < 4; k++) begin
         if (root == 0) begin
            comp[k] = 0;
         end else if (k == br) begin
            comp[k] = longint'(root >> 1);
         end else begin
            mag = (num[k] < 0) ? u64_type'(-num[k]) : u64_type'(num[k]);
            q = longint'((mag << FB) / (2 * root));
            comp[k] = (num[k] < 0) ? -q : q;
         end
      end
      res.w_part = clamp(comp[0]);
      res.x_part = clamp(comp[1]);
      res.y_part = clamp(comp[2]);
      res.z_part = clamp(comp[3]);
      res.branch = rmq_pkg::branch_type'(br);
      res.degenerate = (root == 0);
      return res;
   endfunction

   // mostly short gaps, now and then a long one, often none
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // push one matrix through the req channel; expectation queued on acceptance
   task automatic send_matrix(elem_type m[9], bit known, quat_type typed);
      logic [REQ_W-1:0] word;
      quat_type q;
      int gap;
      word = '0;
      for (int i = 0; i < 9; i++) word[i*DW +: DW] = m[i];
      q = known ? typed : quaternion_of(m);
      if (known && q != quaternion_of(m)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with predictor: %h vs %h", q, quaternion_of(m));
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      quat_queue.push_back(q);
      words_in++;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic elem_type rand_elem();
      int p;
      p = $urandom_range(9);
      if (p == 0) return elem_type'(16'h8000);
      if (p == 1) return elem_type'(16'h7fff);
      if (p < 5) return elem_type'($urandom);
      return elem_type'($urandom_range(2*16384) - 16384);   // within a rotation's range
   endfunction

   // random matrix; a diagonal bias steers it towards one branch, with ties now and then
   task automatic random_matrix(output elem_type m[9]);
      int pick;
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      pick = $urandom_range(5);
      if (pick < 4 && pick > 0) begin
         m[0] = elem_type'(-$urandom_range(16384));
         m[4] = elem_type'(-$urandom_range(16384));
         m[8] = elem_type'(-$urandom_range(16384));
         m[(pick-1)*4] = elem_type'($urandom_range(16384));
      end else if (pick == 4) begin
         m[0] = elem_type'(-$urandom_range(16384));
         m[4] = m[0];
         m[8] = $urandom_range(1) ? m[0] : elem_type'(-$urandom_range(16384));
      end
   endtask

   // directed table
   row_type dir_rows[$];

   function automatic row_type mk(int d0, int d1, int d2, int off, bit known,
                                  quat_type q);
      row_type r;
      for (int i = 0; i < 9; i++) r.m[i] = elem_type'(off);
      r.m[0] = elem_type'(d0); r.m[4] = elem_type'(d1); r.m[8] = elem_type'(d2);
      r.known = known;
      r.q = q;
      return r;
   endfunction

   initial begin
      row_type r;
      elem_type m[9];
      quat_type q;
      // identity: w = sqrt(4)/2 = 1.0
      q = '{degenerate: 1'b0, branch: rmq_pkg::BR_TRACE, z_part: '0, y_part: '0,
            x_part: '0, w_part: 16'sd16384};
      dir_rows.push_back(mk(16384, 16384, 16384, 0, 1'b1, q));
      // 180 deg about x: diag(1,-1,-1)
      q = '{degenerate: 1'b0, branch: rmq_pkg::BR_X, z_part: '0, y_part: '0,
            x_part: 16'sd16384, w_part: '0};
      dir_rows.push_back(mk(16384, -16384, -16384, 0, 1'b1, q));
      q = '{degenerate: 1'b0, branch: rmq_pkg::BR_Y, z_part: '0, y_part: 16'sd16384,
            x_part: '0, w_part: '0};
      dir_rows.push_back(mk(-16384, 16384, -16384, 0, 1'b1, q));
      q = '{degenerate: 1'b0, branch: rmq_pkg::BR_Z, z_part: 16'sd16384, y_part: '0,
            x_part: '0, w_part: '0};
      dir_rows.push_back(mk(-16384, -16384, 16384, 0, 1'b1, q));
      // all zero: trace not positive, full tie falls to m22
      q = '{degenerate: 1'b0, branch: rmq_pkg::BR_Z, z_part: 16'sd8192, y_part: '0,
            x_part: '0, w_part: '0};
      dir_rows.push_back(mk(0, 0, 0, 0, 1'b1, q));
      // ties between diagonals, predictor checked
      dir_rows.push_back(mk(-100, -100, -200, 5, 1'b0, q));
      dir_rows.push_back(mk(-50, -200, -50, -7, 1'b0, q));
      dir_rows.push_back(mk(-300, -20, -20, 9, 1'b0, q));
      // extremes, saturating
      dir_rows.push_back(mk(32767, 32767, 32767, 32767, 1'b0, q));
      dir_rows.push_back(mk(-32768, -32768, -32768, -32768, 1'b0, q));
      dir_rows.push_back(mk(32767, -32768, -32768, 32767, 1'b0, q));
      dir_rows.push_back(mk(-32768, 32767, -32768, -32768, 1'b0, q));
      dir_rows.push_back(mk(-32768, -32768, 32767, 32767, 1'b0, q));
      dir_rows.push_back(mk(1, 0, -1, -32768, 1'b0, q));
      dir_rows.push_back(mk(-16384, -16384, -16384, 32767, 1'b0, q));
      // 90 deg about z, off-diagonal skew drives x,y,z
      r = mk(0, 0, 16384, 0, 1'b0, q);
      r.m[1] = elem_type'(-16384); r.m[3] = elem_type'(16384);
      dir_rows.push_back(r);
      r = mk(-32768, -32768, -32768, 0, 1'b0, q);
      r.m[1] = elem_type'(32767); r.m[3] = elem_type'(32767);
      r.m[2] = elem_type'(-32768); r.m[6] = elem_type'(-32768);
      dir_rows.push_back(r);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_matrix(dir_rows[i].m, dir_rows[i].known, dir_rows[i].q);
      for (int i = 0; i < N_RAND; i++) begin
         random_matrix(m);
         send_matrix(m, 1'b0, q);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // rsp side back-pressure; one nonblocking write to rsp_tready per edge
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = gap_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   end

   // checker: each accepted word against the oldest expectation
   always @(posedge clock) begin
      quat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[4*DW-1:0]};
         words_out++;
         if (quat_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", got);
         end else begin
            want = quat_queue.pop_front();
            branch_seen[want.branch]++;
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("word %0d: want w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0b",
                           words_out, want.w_part, want.x_part, want.y_part,
                           want.z_part, want.branch, want.degenerate);
                  $display("          got  w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0b",
                           got.w_part, got.x_part, got.y_part, got.z_part,
                           got.branch, got.degenerate);
               end
            end
         end
      end
   end

   // end of run and watchdog
   initial begin
      bit timed_out;
      timed_out = 1'b0;
      while (!(stim_done && quat_queue.size() == 0) && !timed_out) begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) timed_out = 1'b1;
      end
      if (!timed_out) repeat (2*LATENCY) @(posedge clock);
      $display("%0d matrices sent, %0d quaternions received", words_in, words_out);
      $display("branches trace/x/y/z = %0d/%0d/%0d/%0d, %0d mismatches",
               branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3],
               mismatches);
      if (timed_out) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
      end else if (mismatches == 0 && quat_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
